### rtl/core/b64sc_pkg.sv
`default_nettype none

package b64sc_pkg;

	// mode register codes
	localparam logic [1:0] MODE_ENC_RAW    = 2'd0;
	localparam logic [1:0] MODE_ENC_PAD    = 2'd1;
	localparam logic [1:0] MODE_DECODE     = 2'd2;
	localparam logic [1:0] MODE_DECODE_ALT = 2'd3;

	// position within a four-character group
	localparam logic [1:0] PH_0 = 2'd0;
	localparam logic [1:0] PH_1 = 2'd1;
	localparam logic [1:0] PH_2 = 2'd2;
	localparam logic [1:0] PH_3 = 2'd3;

	localparam logic [7:0] CHAR_PAD   = 8'h3D;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;
	localparam logic [5:0] VAL_PLUS   = 6'd62;
	localparam logic [5:0] VAL_SLASH  = 6'd63;

	localparam int MAX_RESULTS = 4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_end;
		logic       bad_char;
		logic       truncated;
	} out_t;

	typedef struct packed {
		logic [1:0] group_phase;
		logic [3:0] carry_bits;
		logic [5:0] first_six;
		logic       pad_skip;
		logic       bad_seen;
	} codec_state_t;

	// results caused by one request
	typedef struct packed {
		logic [MAX_RESULTS-1:0][7:0] chars;
		logic [2:0]                  count;
		logic                        trunc;
	} batch_t;

	typedef struct packed {
		logic       ok;
		logic [5:0] val;
	} dec_t;

	function automatic logic [7:0] enc6(input logic [5:0] v);
		logic [7:0] w;
		w = {2'b00, v};
		if (v < 6'd26)
			return 8'h41 + w;
		else if (v < 6'd52)
			return 8'h61 + w - 8'd26;
		else if (v < VAL_PLUS)
			return 8'h30 + w - 8'd52;
		else if (v == VAL_PLUS)
			return CHAR_PLUS;
		else
			return CHAR_SLASH;
	endfunction

	function automatic dec_t dec6(input logic [7:0] c);
		dec_t d;
		d.ok = 1'b1;
		if (c >= 8'h41 && c <= 8'h5A)
			d.val = 6'(c - 8'h41);
		else if (c >= 8'h61 && c <= 8'h7A)
			d.val = 6'(c - 8'h61 + 8'd26);
		else if (c >= 8'h30 && c <= 8'h39)
			d.val = 6'(c - 8'h30 + 8'd52);
		else if (c == CHAR_PLUS)
			d.val = VAL_PLUS;
		else if (c == CHAR_SLASH)
			d.val = VAL_SLASH;
		else begin
			d.ok  = 1'b0;
			d.val = VAL_SLASH;
		end
		return d;
	endfunction

endpackage

`default_nettype wire

### rtl/core/b64sc_step.sv
`default_nettype none

// next state and result batch for one request
module b64sc_step (
	input  wire logic [1:0]             mode,
	input  wire b64sc_pkg::codec_state_t state,
	input  wire b64sc_pkg::in_t          item,
	output b64sc_pkg::codec_state_t      next_state,
	output b64sc_pkg::batch_t            batch
);
	import b64sc_pkg::*;

	logic       decode;
	logic       padded;
	logic [1:0] ph;
	logic [7:0] b;
	dec_t       d;

	assign decode = (mode == MODE_DECODE) || (mode == MODE_DECODE_ALT);
	assign padded = (mode == MODE_ENC_PAD);
	assign b      = item.data_byte;
	assign d      = dec6(b);

	always_comb begin
		next_state  = state;
		batch.chars = '0;
		batch.count = 3'd0;
		batch.trunc = 1'b0;
		ph          = state.group_phase;

		if (!decode) begin
			if (ph == PH_3)
				ph = PH_0;
			case (ph)
				PH_0: begin
					batch.chars[0]         = enc6(b[7:2]);
					batch.count            = 3'd1;
					next_state.carry_bits  = {2'b00, b[1:0]};
					next_state.group_phase = PH_1;
					if (item.last_byte) begin
						batch.chars[1] = enc6({b[1:0], 4'b0000});
						batch.chars[2] = CHAR_PAD;
						batch.chars[3] = CHAR_PAD;
						batch.count    = padded ? 3'd4 : 3'd2;
					end
				end
				PH_1: begin
					batch.chars[0]         = enc6({state.carry_bits[1:0], b[7:4]});
					batch.count            = 3'd1;
					next_state.carry_bits  = b[3:0];
					next_state.group_phase = PH_2;
					if (item.last_byte) begin
						batch.chars[1] = enc6({b[3:0], 2'b00});
						batch.chars[2] = CHAR_PAD;
						batch.count    = padded ? 3'd3 : 3'd2;
					end
				end
				default: begin
					batch.chars[0]         = enc6({state.carry_bits, b[7:6]});
					batch.chars[1]         = enc6(b[5:0]);
					batch.count            = 3'd2;
					next_state.carry_bits  = 4'd0;
					next_state.group_phase = PH_0;
				end
			endcase
		end else if (ph == PH_3 && state.pad_skip) begin
			next_state.pad_skip    = 1'b0;
			next_state.group_phase = PH_0;
		end else if ((ph == PH_2 || ph == PH_3) && b == CHAR_PAD) begin
			// padding ends the group; at position 2 the following char is dropped
			next_state.pad_skip    = (ph == PH_2);
			next_state.group_phase = (ph == PH_2) ? PH_3 : PH_0;
		end else begin
			if (!d.ok)
				next_state.bad_seen = 1'b1;
			case (ph)
				PH_0: begin
					next_state.first_six   = d.val;
					next_state.pad_skip    = 1'b0;
					next_state.group_phase = PH_1;
					if (item.last_byte) begin
						batch.count = 3'd1;
						batch.trunc = 1'b1;
					end
				end
				PH_1: begin
					batch.chars[0]         = {state.first_six, d.val[5:4]};
					batch.count            = 3'd1;
					next_state.carry_bits  = d.val[3:0];
					next_state.group_phase = PH_2;
				end
				PH_2: begin
					batch.chars[0]         = {state.carry_bits, d.val[5:2]};
					batch.count            = 3'd1;
					next_state.carry_bits  = {2'b00, d.val[1:0]};
					next_state.group_phase = PH_3;
				end
				default: begin
					batch.chars[0]         = {state.carry_bits[1:0], d.val};
					batch.count            = 3'd1;
					next_state.carry_bits  = 4'd0;
					next_state.group_phase = PH_0;
				end
			endcase
		end

		if (item.last_byte) begin
			next_state.group_phase = PH_0;
			next_state.carry_bits  = 4'd0;
			next_state.first_six   = 6'd0;
			next_state.pad_skip    = 1'b0;
		end
	end

endmodule

`default_nettype wire

### rtl/core/base64_stream_codec.sv
`default_nettype none

// base64 stream codec, one byte per request on the item channel
// item channel: item_valid / item_stall, payload item (data_byte, last_byte)
// result channel: result_valid / result_stall, payload result (out_byte,
//   run_end, bad_char, truncated), one result per cycle at most
// config channel: cfg_valid / cfg_ready, cfg_data is the mode register
//   (0 raw encode, 1 padded encode, 2 or 3 decode); cfg_ready is always high,
//   write it only while no request is in flight
// a request yields zero to four results; the last one carries run_end
// the first result of an accepted request passes the batch register, then the
//   result register; a request holds the batch register until all its results
//   have moved on, and one with no results does not load it; plain encode
//   gives four results per three bytes (two for the byte that closes a group),
//   decode at most one a character, a final padded byte four
// the batch register is refilled in the cycle its last result moves out, so
//   a new request is taken while the previous result still sits in the
//   result register
// reset clears mode, group position, leftover bits and the sticky error flag;
//   no result is valid after reset
// when the receiver stalls the result register holds, the batch backs up and
//   item_stall rises until the batch can drain again
module base64_stream_codec (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            item_valid,
	output logic                 item_stall,
	input  wire b64sc_pkg::in_t  item,
	output logic                 result_valid,
	input  wire logic            result_stall,
	output b64sc_pkg::out_t      result,
	input  wire logic            cfg_valid,
	output logic                 cfg_ready,
	input  wire logic [1:0]      cfg_data
);
	import b64sc_pkg::*;

	// configuration and codec state
	logic [1:0]   mode_q;
	codec_state_t state_q;
	codec_state_t next_state;
	batch_t       step_batch;

	// batch register: pending results of the latest request
	logic [MAX_RESULTS-1:0][7:0] chars_s1;
	logic [1:0]                  last_idx_s1;
	logic [1:0]                  idx_s1;
	logic                        bad_s1;
	logic                        trunc_s1;
	logic                        batch_valid_s1;

	// result register
	out_t res_s2;
	logic res_valid_s2;

	logic accept;
	logic out_free;
	logic move;
	logic last_move;

	assign cfg_ready = 1'b1;

	b64sc_step u_step (
		.mode       (mode_q),
		.state      (state_q),
		.item       (item),
		.next_state (next_state),
		.batch      (step_batch)
	);

	// handshake glue
	assign out_free   = !res_valid_s2 || !result_stall;
	assign move       = batch_valid_s1 && out_free;
	assign last_move  = move && (idx_s1 == last_idx_s1);
	assign item_stall = batch_valid_s1 && !last_move;
	assign accept     = item_valid && !item_stall;

	assign result_valid = res_valid_s2;
	assign result       = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ENC_RAW;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	// state moves on every accepted request, even one with no results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (accept) begin
			state_q <= next_state;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			batch_valid_s1 <= 1'b0;
			idx_s1         <= 2'd0;
		end else if (accept && step_batch.count != 3'd0) begin
			batch_valid_s1 <= 1'b1;
			idx_s1         <= 2'd0;
		end else if (last_move) begin
			batch_valid_s1 <= 1'b0;
		end else if (move) begin
			idx_s1 <= idx_s1 + 2'd1;
		end
	end

	// batch payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept && step_batch.count != 3'd0) begin
			chars_s1    <= step_batch.chars;
			last_idx_s1 <= 2'(step_batch.count - 3'd1);
			bad_s1      <= next_state.bad_seen;
			trunc_s1    <= step_batch.trunc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (move) begin
			res_valid_s2 <= 1'b1;
		end else if (out_free) begin
			res_valid_s2 <= 1'b0;
		end
	end

	// truncation is only ever a single-result batch, so it rides on that one
	always_ff @(posedge clk) begin
		if (move) begin
			res_s2.out_byte  <= chars_s1[idx_s1];
			res_s2.run_end   <= (idx_s1 == last_idx_s1);
			res_s2.bad_char  <= bad_s1;
			res_s2.truncated <= trunc_s1 && (idx_s1 == last_idx_s1);
		end
	end

	// read pointer never runs past the end of the batch
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		batch_valid_s1 |-> idx_s1 <= last_idx_s1)
		else $error("batch read pointer past last result");

	// a final byte returns the group to its start
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.last_byte |=> state_q.group_phase == PH_0 && !state_q.pad_skip)
		else $error("group state not cleared after final byte");

	// the invalid-character flag is sticky
	a_bad_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.bad_seen |=> state_q.bad_seen)
		else $error("sticky error flag dropped");

	// a truncation report always closes its request
	a_trunc_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 && res_s2.truncated |-> res_s2.run_end)
		else $error("truncated result without run_end");

endmodule

`default_nettype wire

### verif/base64_stream_codec_tb.sv
module base64_stream_codec_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import b64sc_pkg::*;

	// cycles the codec gets to settle after its last result before a mode write or pause
	localparam int SETTLE_CYCLES = 6;
	// quiet cycles at the end of the run
	localparam int TAIL_CYCLES   = 8;
	// the one long receiver hold-off
	localparam int HOLD_CYCLES   = 120;
	localparam int RANDOM_ITEMS  = 180;

	// what one entry of the stimulus list asks the driver to do
	typedef enum logic [1:0] {ACT_ITEM, ACT_MODE, ACT_SYNC, ACT_HOLD} act_e;

	typedef struct {
		act_e       kind;
		in_t        it;
		logic [1:0] mode;
		int         gap;
	} stim_t;

	logic       clk;
	logic       arst_n       = 1'b0;
	logic       item_valid   = 1'b0;
	in_t        item         = '0;
	logic       item_stall;
	logic       result_valid;
	logic       result_stall = 1'b0;
	out_t       result;
	logic       cfg_valid    = 1'b0;
	logic [1:0] cfg_data     = MODE_ENC_RAW;
	logic       cfg_ready;

	// stimulus list and the results still owed by the codec
	stim_t request_q [$];
	out_t  pending_out [$];

	// handshake counters, written only by the monitor; the failure count also grows at the end of the run
	int items_taken  = 0;
	int results_seen = 0;
	int cfgs_taken   = 0;
	int fail_cnt     = 0;

	logic hold_go   = 1'b0;
	logic long_hold = 1'b0;

	// sender idle pattern used while the list is built
	int   tx_left       = 0;
	logic tx_calm       = 1'b0;
	logic tx_force_calm = 1'b0;
	int   queued_items  = 0;

	// predictor state
	logic [1:0] pm_mode   = MODE_ENC_RAW;
	logic [1:0] pm_phase  = PH_0;
	logic [3:0] pm_carry  = '0;
	logic [5:0] pm_first  = '0;
	logic       pm_skip   = 1'b0;
	logic       pm_bad    = 1'b0;

	base64_stream_codec DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// single reset at the start, released on a falling edge
	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// hard stop in case the codec hangs
	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// 6-bit value to base64 alphabet
	function automatic logic [7:0] sextet_char(input logic [5:0] v);
		if (v < 6'd26)
			return 8'h41 + {2'b00, v};
		else if (v < 6'd52)
			return 8'h61 + {2'b00, v} - 8'd26;
		else if (v < VAL_PLUS)
			return 8'h30 + {2'b00, v} - 8'd52;
		else if (v == VAL_PLUS)
			return CHAR_PLUS;
		return CHAR_SLASH;
	endfunction

	// base64 character to {valid, value}; anything else maps to 63
	function automatic logic [6:0] char_sextet(input logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5A)
			return {1'b1, 6'(c - 8'h41)};
		if (c >= 8'h61 && c <= 8'h7A)
			return {1'b1, 6'(c - 8'h61 + 8'd26)};
		if (c >= 8'h30 && c <= 8'h39)
			return {1'b1, 6'(c - 8'h30 + 8'd52)};
		if (c == CHAR_PLUS)
			return {1'b1, VAL_PLUS};
		if (c == CHAR_SLASH)
			return {1'b1, VAL_SLASH};
		return {1'b0, VAL_SLASH};
	endfunction

	// advance the predicted codec by one request and queue what it owes
	task automatic codec_step(input in_t it);
		logic [7:0] chr [$];
		logic       trunc_flag;
		logic [1:0] ph;
		logic [6:0] dv;
		logic [7:0] b;
		out_t       r;
		chr = {};
		trunc_flag = 1'b0;
		ph = pm_phase;
		b = it.data_byte;
		if (pm_mode == MODE_DECODE || pm_mode == MODE_DECODE_ALT) begin
			if (ph == PH_3 && pm_skip) begin
				// character after a pad at position two is dropped
				pm_skip = 1'b0;
				pm_phase = PH_0;
			end else if ((ph == PH_2 || ph == PH_3) && b == CHAR_PAD) begin
				pm_skip = (ph == PH_2);
				pm_phase = (ph == PH_2) ? PH_3 : PH_0;
			end else begin
				dv = char_sextet(b);
				if (!dv[6])
					pm_bad = 1'b1;
				case (ph)
					PH_0: begin
						pm_first = dv[5:0];
						pm_skip = 1'b0;
						pm_phase = PH_1;
						// lone final character
						if (it.last_byte) begin
							chr.push_back(8'h00);
							trunc_flag = 1'b1;
						end
					end
					PH_1: begin
						chr.push_back({pm_first, dv[5:4]});
						pm_carry = dv[3:0];
						pm_phase = PH_2;
					end
					PH_2: begin
						chr.push_back({pm_carry, dv[5:2]});
						pm_carry = {2'b00, dv[1:0]};
						pm_phase = PH_3;
					end
					default: begin
						chr.push_back({pm_carry[1:0], dv[5:0]});
						pm_carry = '0;
						pm_phase = PH_0;
					end
				endcase
			end
		end else begin
			// encode treats position three as a fresh group
			if (ph == PH_3)
				ph = PH_0;
			case (ph)
				PH_0: begin
					chr.push_back(sextet_char(b[7:2]));
					pm_carry = {2'b00, b[1:0]};
					pm_phase = PH_1;
					if (it.last_byte) begin
						chr.push_back(sextet_char({b[1:0], 4'b0000}));
						if (pm_mode == MODE_ENC_PAD) begin
							chr.push_back(CHAR_PAD);
							chr.push_back(CHAR_PAD);
						end
					end
				end
				PH_1: begin
					chr.push_back(sextet_char({pm_carry[1:0], b[7:4]}));
					pm_carry = b[3:0];
					pm_phase = PH_2;
					if (it.last_byte) begin
						chr.push_back(sextet_char({b[3:0], 2'b00}));
						if (pm_mode == MODE_ENC_PAD)
							chr.push_back(CHAR_PAD);
					end
				end
				default: begin
					chr.push_back(sextet_char({pm_carry, b[7:6]}));
					chr.push_back(sextet_char(b[5:0]));
					pm_carry = '0;
					pm_phase = PH_0;
				end
			endcase
		end
		// final byte closes the stream
		if (it.last_byte) begin
			pm_phase = PH_0;
			pm_carry = '0;
			pm_first = '0;
			pm_skip = 1'b0;
		end
		foreach (chr[k]) begin
			r.out_byte = chr[k];
			r.run_end = (k == chr.size() - 1);
			r.bad_char = pm_bad;
			r.truncated = trunc_flag;
			pending_out.push_back(r);
		end
	endtask

	task automatic report_mismatch(input string what, input out_t want, input out_t got);
		fail_cnt++;
		if (fail_cnt <= 10)
			$display("%s: expected byte %h end %b bad %b trunc %b, got byte %h end %b bad %b trunc %b",
				what, want.out_byte, want.run_end, want.bad_char, want.truncated,
				got.out_byte, got.run_end, got.bad_char, got.truncated);
	endtask

	// list building: one request, with its own lead-in gap
	task automatic add_item(input logic [7:0] b, input logic last);
		stim_t s;
		s.kind = ACT_ITEM;
		s.it.data_byte = b;
		s.it.last_byte = last;
		s.mode = MODE_ENC_RAW;
		if (tx_force_calm) begin
			s.gap = 0;
		end else begin
			// stretches of back-to-back requests mixed with random gaps
			if (tx_left == 0) begin
				tx_left = $urandom_range(6, 30);
				tx_calm = ($urandom_range(0, 2) == 0);
			end
			tx_left--;
			s.gap = tx_calm ? 0 : $urandom_range(0, 7);
		end
		request_q.push_back(s);
		queued_items++;
	endtask

	task automatic add_ctrl(input act_e kind, input logic [1:0] m);
		stim_t s;
		s.kind = kind;
		s.it = '0;
		s.mode = m;
		s.gap = 0;
		request_q.push_back(s);
	endtask

	// monitor: requests, mode writes and results on the rising edge
	always @(posedge clk) begin : watch
		out_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (pending_out.size() == 0) begin
					report_mismatch("unexpected result", '0, result);
				end else begin
					want = pending_out.pop_front();
					if (result.out_byte !== want.out_byte || result.run_end !== want.run_end ||
							result.bad_char !== want.bad_char ||
							result.truncated !== want.truncated)
						report_mismatch("mismatch", want, result);
				end
				results_seen++;
			end
			if (cfg_valid && cfg_ready) begin
				// mode write keeps stream state and the sticky error
				pm_mode = cfg_data;
				cfgs_taken++;
			end
			if (item_valid && !item_stall) begin
				codec_step(item);
				items_taken++;
			end
		end
	end

	// driver: walks the stimulus list on the falling edge
	always @(negedge clk) begin : drive
		int         drv_items;
		int         drv_cfgs;
		int         wait_cnt;
		int         settle_cnt;
		stim_t      head;
		logic       nxt_valid;
		in_t        nxt_item;
		logic       nxt_cfg_valid;
		logic [1:0] nxt_cfg;
		nxt_valid = item_valid;
		nxt_item = item;
		nxt_cfg_valid = cfg_valid;
		nxt_cfg = cfg_data;
		if (arst_n) begin
			// drop valid once the request went through
			if (item_valid && items_taken != drv_items) begin
				drv_items = items_taken;
				nxt_valid = 1'b0;
			end
			if (cfg_valid && cfgs_taken != drv_cfgs) begin
				drv_cfgs = cfgs_taken;
				nxt_cfg_valid = 1'b0;
			end
			if (!nxt_valid && !nxt_cfg_valid && request_q.size() != 0) begin
				head = request_q[0];
				if (head.kind == ACT_ITEM) begin
					if (wait_cnt < head.gap) begin
						wait_cnt++;
					end else begin
						wait_cnt = 0;
						nxt_valid = 1'b1;
						nxt_item = head.it;
						void'(request_q.pop_front());
					end
				end else if (head.kind == ACT_HOLD) begin
					// kick off the long receiver hold-off
					hold_go <= 1'b1;
					void'(request_q.pop_front());
				end else begin
					// mode writes and pauses wait until the codec is drained
					if (pending_out.size() != 0) begin
						settle_cnt = 0;
					end else if (settle_cnt < SETTLE_CYCLES) begin
						settle_cnt++;
					end else begin
						settle_cnt = 0;
						if (head.kind == ACT_MODE) begin
							nxt_cfg_valid = 1'b1;
							nxt_cfg = head.mode;
						end
						void'(request_q.pop_front());
					end
				end
			end
		end
		item_valid <= nxt_valid;
		item <= nxt_item;
		cfg_valid <= nxt_cfg_valid;
		cfg_data <= nxt_cfg;
	end

	// long hold-off, counted here while the sender keeps offering
	initial begin
		wait (hold_go);
		@(posedge clk);
		long_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		long_hold = 1'b0;
	end

	// receiver: random stall before each result, with calm stretches
	always @(negedge clk) begin : recv
		int   rx_seen;
		int   rx_gap;
		int   rx_left;
		logic rx_calm;
		if (results_seen != rx_seen) begin
			rx_seen = results_seen;
			if (rx_left == 0) begin
				rx_left = $urandom_range(8, 40);
				rx_calm = ($urandom_range(0, 2) == 0);
			end
			rx_left--;
			rx_gap = rx_calm ? 0 : $urandom_range(0, 7);
		end
		if (long_hold) begin
			result_stall <= 1'b1;
		end else if (rx_gap > 0) begin
			result_stall <= 1'b1;
			rx_gap--;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// stimulus list, then end of run
	initial begin : stimulus
		logic [7:0] raw [$];
		logic [7:0] chars [$];
		logic [1:0] m;
		int         streams;
		int         len;
		int         pick;
		int         acc;
		int         nbits;
		int         bad_at;
		logic       padded;
		logic       hold_placed;
		logic       no_last;
		hold_placed = 1'b0;

		// raw encode: full group, one-byte and two-byte flush
		add_ctrl(ACT_MODE, MODE_ENC_RAW);
		add_item(8'h00, 1'b0);
		add_item(8'hFF, 1'b0);
		add_item(8'h80, 1'b1);
		add_item(8'hFC, 1'b1);
		add_item(8'h03, 1'b0);
		add_item(8'hF0, 1'b1);

		// padded encode: two pads, one pad, none
		add_ctrl(ACT_MODE, MODE_ENC_PAD);
		add_item(8'hFF, 1'b1);
		add_item(8'h00, 1'b0);
		add_item(8'h10, 1'b1);
		add_item(8'h41, 1'b0);
		add_item(8'h42, 1'b0);
		add_item(8'h43, 1'b1);

		// decode: double pad with the skipped char, single pad
		add_ctrl(ACT_MODE, MODE_DECODE);
		add_item("T", 1'b0);
		add_item("Q", 1'b0);
		add_item(CHAR_PAD, 1'b0);
		add_item(CHAR_PAD, 1'b1);
		add_item("T", 1'b0);
		add_item("W", 1'b0);
		add_item("E", 1'b0);
		add_item(CHAR_PAD, 1'b1);
		// pad too early, invalid char, plus and slash
		add_item(CHAR_PAD, 1'b0);
		add_item("*", 1'b0);
		add_item(CHAR_PLUS, 1'b0);
		add_item(CHAR_SLASH, 1'b1);
		// lone final character
		add_item("A", 1'b1);

		// alternate decode code, left mid-group before switching to encode
		add_ctrl(ACT_MODE, MODE_DECODE_ALT);
		add_item("Q", 1'b0);
		add_item("U", 1'b0);
		add_item(CHAR_PAD, 1'b0);
		add_ctrl(ACT_MODE, MODE_ENC_RAW);
		add_item(8'h7F, 1'b1);
		add_ctrl(ACT_SYNC, MODE_ENC_RAW);

		// random phases, each under one mode
		while (queued_items < RANDOM_ITEMS) begin
			m = 2'($urandom_range(0, 3));
			streams = $urandom_range(2, 6);
			if (!hold_placed && queued_items >= 90) begin
				// back-to-back decode burst under the long hold-off
				m = MODE_DECODE;
				streams = 8;
				add_ctrl(ACT_MODE, m);
				add_ctrl(ACT_HOLD, m);
				tx_force_calm = 1'b1;
				hold_placed = 1'b1;
			end else begin
				add_ctrl(ACT_MODE, m);
			end
			for (int s = 0; s < streams; s++) begin
				len = $urandom_range(1, 6);
				raw = {};
				for (int k = 0; k < len; k++)
					raw.push_back(8'($urandom));
				if (m == MODE_DECODE || m == MODE_DECODE_ALT) begin
					pick = tx_force_calm ? 2 : $urandom_range(0, 7);
					if (pick == 0) begin
						// noise: arbitrary bytes, maybe no end marker
						no_last = $urandom_range(0, 1);
						foreach (raw[k])
							add_item(raw[k], !no_last && k == raw.size() - 1);
					end else begin
						// well-formed text built from random bytes
						chars = {};
						acc = 0;
						nbits = 0;
						foreach (raw[k]) begin
							acc = (acc << 8) | raw[k];
							nbits += 8;
							while (nbits >= 6) begin
								chars.push_back(sextet_char(6'(acc >> (nbits - 6))));
								nbits -= 6;
								acc &= (1 << nbits) - 1;
							end
						end
						if (nbits > 0)
							chars.push_back(sextet_char(6'(acc << (6 - nbits))));
						padded = $urandom_range(0, 1);
						while (padded && chars.size() % 4 != 0)
							chars.push_back(CHAR_PAD);
						// broken text: one char replaced by any byte
						if (pick == 1) begin
							bad_at = $urandom_range(0, chars.size() - 1);
							chars[bad_at] = 8'($urandom);
						end
						foreach (chars[k])
							add_item(chars[k], k == chars.size() - 1);
					end
				end else begin
					// encode stream, now and then left open
					no_last = ($urandom_range(0, 7) == 0);
					foreach (raw[k])
						add_item(raw[k], !no_last && k == raw.size() - 1);
				end
				if (!tx_force_calm && $urandom_range(0, 5) == 0)
					add_ctrl(ACT_SYNC, m);
			end
			tx_force_calm = 1'b0;
		end

		// wait for the list to run out, then for the codec to drain
		do @(posedge clk); while (request_q.size() != 0 || item_valid || cfg_valid);
		do @(negedge clk); while (pending_out.size() != 0);
		repeat (TAIL_CYCLES) @(negedge clk);
		fail_cnt += pending_out.size();

		$display("run covered %0d requests, %0d results and %0d mode writes",
			items_taken, results_seen, cfgs_taken);
		$display("all four modes, pad and flush cases, bad and lone chars, stalls and hold-off");
		if (fail_cnt == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
